@@ design/pds_pkg.sv @@
`default_nettype none
package pds_pkg;

  // Width of the reported divisor sum; larger sums saturate.
  localparam int unsigned SUM_WIDTH = 35;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_ACCUM,
    ST_FINISH
  } pds_state_t;

endpackage
`default_nettype wire

@@ design/pds_if.sv @@
`default_nettype none
// Input stream: one unsigned value per transaction.
interface pds_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// Result stream: divisor sum and perfect flag per transaction.
interface pds_out_if;
  import pds_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [SUM_WIDTH-1:0] divisor_sum;
  logic                 is_perfect;

  modport source (output valid, output divisor_sum, output is_perfect, input ready);
  modport sink   (input valid, input divisor_sum, input is_perfect, output ready);
endinterface
`default_nettype wire

@@ design/proper_divisor_sum_perfect_test.sv @@
`default_nettype none
// Sequencing: for n >= 2 each trial divisor from 2 up to floor(sqrt(n)) passes through a check
// state, a restoring division of n by the divisor and an accumulate state before the finish state
// registers the result; n of 0 or 1 goes straight from idle to the finish state.
// Throughput: one transaction at a time; in_port.ready is high only while the sequencer idles,
// and the next value is taken while a finished result still waits in the output register.
// Reset (synchronous, active low) returns the sequencer to idle and drops out_port.valid.
module proper_divisor_sum_perfect_test #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pds_in_if.sink    in_port,
  pds_out_if.source out_port
);
  import pds_pkg::*;

  // Divisor, square and accumulator widths follow from the value width.
  localparam int unsigned D_W   = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int unsigned SQ_W  = VALUE_WIDTH + 1;
  localparam int unsigned ACC_W = (VALUE_WIDTH + 3 > SUM_WIDTH + 1) ? VALUE_WIDTH + 3
                                                                    : SUM_WIDTH + 1;
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

  pds_state_t state_r, state_nxt;

  logic [VALUE_WIDTH-1:0] n_r, n_nxt;
  logic [D_W-1:0]         d_r, d_nxt;
  logic [SQ_W-1:0]        sq_r, sq_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [D_W-1:0]         rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SUM_WIDTH-1:0]   out_sum_r, out_sum_nxt;
  logic                   out_perf_r, out_perf_nxt;

  logic in_fire;
  logic out_free;
  logic past_root;
  logic div_last;
  logic [D_W:0]   shifted;
  logic [D_W:0]   trial;
  logic           trial_ok;
  logic           saturated;

  assign in_fire   = in_port.valid && in_port.ready;
  assign out_free  = !out_valid_r || out_port.ready;
  assign past_root = sq_r > {1'b0, n_r};
  assign div_last  = cnt_r == '0;

  // Restoring division step: shift in the next dividend bit and try to subtract.
  assign shifted  = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign trial    = shifted - {1'b0, d_r};
  assign trial_ok = shifted >= {1'b0, d_r};

  assign saturated = |acc_r[ACC_W-1:SUM_WIDTH];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_port.value < VALUE_WIDTH'(2)) ? ST_FINISH : ST_CHECK;
        end
      end
      ST_CHECK:  state_nxt = past_root ? ST_FINISH : ST_DIVIDE;
      ST_DIVIDE: state_nxt = div_last ? ST_ACCUM : ST_DIVIDE;
      ST_ACCUM:  state_nxt = ST_CHECK;
      ST_FINISH: state_nxt = out_free ? ST_IDLE : ST_FINISH;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_port.ready        = state_r == ST_IDLE;
    out_port.valid       = out_valid_r;
    out_port.divisor_sum = out_sum_r;
    out_port.is_perfect  = out_perf_r;
  end

  // Datapath next values.
  always_comb begin
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    out_sum_nxt   = out_sum_r;
    out_perf_nxt  = out_perf_r;
    out_valid_nxt = out_valid_r && !out_port.ready;
    unique case (state_r)
      ST_IDLE: begin
        // Start a transaction: 1 divides every n >= 2.
        n_nxt   = in_port.value;
        d_nxt   = D_W'(2);
        sq_nxt  = SQ_W'(4);
        acc_nxt = (in_port.value < VALUE_WIDTH'(2)) ? '0 : ACC_W'(1);
      end
      ST_CHECK: begin
        rem_nxt = '0;
        quo_nxt = n_r;
        cnt_nxt = CNT_W'(VALUE_WIDTH - 1);
      end
      ST_DIVIDE: begin
        rem_nxt = trial_ok ? trial[D_W-1:0] : shifted[D_W-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], trial_ok};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      ST_ACCUM: begin
        // Add the divisor and its partner; a square root is counted once.
        if (rem_r == '0) begin
          if (quo_r != {{(VALUE_WIDTH-D_W){1'b0}}, d_r}) begin
            acc_nxt = acc_r + {{(ACC_W-D_W){1'b0}}, d_r}
                            + {{(ACC_W-VALUE_WIDTH){1'b0}}, quo_r};
          end else begin
            acc_nxt = acc_r + {{(ACC_W-D_W){1'b0}}, d_r};
          end
        end
        sq_nxt = sq_r + {{(SQ_W-D_W-1){1'b0}}, d_r, 1'b1};
        d_nxt  = d_r + D_W'(1);
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = saturated ? '1 : acc_r[SUM_WIDTH-1:0];
          out_perf_nxt  = (n_r != '0) && (acc_r == {{(ACC_W-VALUE_WIDTH){1'b0}}, n_r});
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_port.ready;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    sq_r       <= sq_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    out_sum_r  <= out_sum_nxt;
    out_perf_r <= out_perf_nxt;
  end

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import pds_pkg::*;

  localparam int unsigned VW = 32;
  localparam int unsigned N_RANDOM = 80;
  // Cycles the receiver holds off at the start of the random part. Long enough for
  // the block to finish one value, park it, take a second one and stall its input.
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [SUM_WIDTH-1:0] divisor_sum;
    logic                 is_perfect;
  } divisor_result_t;

  typedef struct packed {
    logic [VW-1:0]        value;
    logic                 typed;
    logic [SUM_WIDTH-1:0] divisor_sum;
    logic                 is_perfect;
  } stim_row_t;

  logic clk;
  logic rst_n;

  pds_in_if #(.VALUE_WIDTH(VW)) in_ch ();
  pds_out_if                    out_ch ();

  proper_divisor_sum_perfect_test #(
    .VALUE_WIDTH(VW)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_port (in_ch),
    .out_port(out_ch)
  );

  // Expected results, oldest first.
  divisor_result_t sum_q[$];

  // Typed-in expectation travelling with the value currently offered.
  logic                 row_typed;
  logic [SUM_WIDTH-1:0] row_sum;
  logic                 row_perfect;

  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_perfect_seen;
  bit          hold_go;

  // Directed stimulus: edges of the range, perfect numbers, squares and primes.
  stim_row_t dir_rows [20];

  always #1 clk = ~clk;

  // Sum of proper divisors by trial division, square root counted once.
  function automatic divisor_result_t predict_divisor_sum(input logic [VW-1:0] value);
    longint unsigned n;
    longint unsigned total;
    longint unsigned d;
    longint unsigned sum_max;
    divisor_result_t res;
    n = value;
    total = 0;
    sum_max = (64'd1 << SUM_WIDTH) - 1;
    if (n >= 2) begin
      total = 1;
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) begin
          total += d;
          if (n / d != d) total += n / d;
        end
      end
    end
    res.divisor_sum = (total > sum_max) ? sum_max[SUM_WIDTH-1:0] : total[SUM_WIDTH-1:0];
    res.is_perfect  = (n != 0) && (n == total);
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    n_errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Offers one value and returns at the edge where the transaction is taken.
  task automatic send_value(input logic [VW-1:0] v, input logic typed,
                            input logic [SUM_WIDTH-1:0] s, input logic p,
                            input bit may_idle);
    while (may_idle && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    row_typed   <= typed;
    row_sum     <= s;
    row_perfect <= p;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Random value, mostly small so that trial division stays short.
  function automatic logic [VW-1:0] pick_value(input int unsigned idx);
    int unsigned mode;
    logic [VW-1:0] v;
    mode = $urandom_range(99);
    if (idx < 12) v = $urandom_range(63);
    else if (mode < 8) begin
      case ($urandom_range(3))
        0: v = 6;
        1: v = 28;
        2: v = 496;
        default: v = 8128;
      endcase
      v = v + $urandom_range(2) - 1;
    end else if (mode < 80) v = $urandom_range(4095);
    else if (mode < 95) v = $urandom_range(65535);
    else v = $urandom_range((1 << 20) - 1);
    return v;
  endfunction

  // Input monitor: one expectation per accepted transaction.
  always @(posedge clk) begin
    divisor_result_t exp_in;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      n_accepted++;
      if (row_typed) begin
        exp_in.divisor_sum = row_sum;
        exp_in.is_perfect  = row_perfect;
      end else begin
        exp_in = predict_divisor_sum(in_ch.value);
      end
      sum_q = {sum_q, exp_in};
    end
  end

  // Output monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    divisor_result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sum_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result sum=%0d perfect=%0b",
                                out_ch.divisor_sum, out_ch.is_perfect));
      end else begin
        exp_res = sum_q.pop_front();
        n_checked++;
        if (out_ch.is_perfect) n_perfect_seen++;
        if (out_ch.divisor_sum !== exp_res.divisor_sum)
          flag_mismatch($sformatf("result %0d divisor_sum got %0d want %0d", n_checked,
                                  out_ch.divisor_sum, exp_res.divisor_sum));
        if (out_ch.is_perfect !== exp_res.is_perfect)
          flag_mismatch($sformatf("result %0d is_perfect got %0b want %0b", n_checked,
                                  out_ch.is_perfect, exp_res.is_perfect));
      end
    end
  end

  // Receiver: random stalls, one long hold-off, and a quiet window with none.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (n_checked >= 40 && n_checked < 70) out_ch.ready <= 1'b1;
        else out_ch.ready <= ($urandom_range(99) >= 9);
        @(posedge clk);
      end
    end
  end

  // Reset, directed table, then random values.
  initial begin
    stim_row_t row;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    row_typed = 1'b0;
    row_sum = '0;
    row_perfect = 1'b0;
    n_accepted = 0;
    n_checked = 0;
    n_errors = 0;
    n_perfect_seen = 0;
    hold_go = 1'b0;
    dir_rows = '{
      '{value: 32'd0,          typed: 1'b1, divisor_sum: 35'd0,        is_perfect: 1'b0},
      '{value: 32'd1,          typed: 1'b1, divisor_sum: 35'd0,        is_perfect: 1'b0},
      '{value: 32'd2,          typed: 1'b1, divisor_sum: 35'd1,        is_perfect: 1'b0},
      '{value: 32'd3,          typed: 1'b1, divisor_sum: 35'd1,        is_perfect: 1'b0},
      '{value: 32'd4,          typed: 1'b0, divisor_sum: '0,           is_perfect: 1'b0},
      '{value: 32'd9,          typed: 1'b1, divisor_sum: 35'd4,        is_perfect: 1'b0},
      '{value: 32'd6,          typed: 1'b1, divisor_sum: 35'd6,        is_perfect: 1'b1},
      '{value: 32'd28,         typed: 1'b1, divisor_sum: 35'd28,       is_perfect: 1'b1},
      '{value: 32'd496,        typed: 1'b1, divisor_sum: 35'd496,      is_perfect: 1'b1},
      '{value: 32'd8128,       typed: 1'b1, divisor_sum: 35'd8128,     is_perfect: 1'b1},
      '{value: 32'd33550336,   typed: 1'b1, divisor_sum: 35'd33550336, is_perfect: 1'b1},
      '{value: 32'd12,         typed: 1'b0, divisor_sum: '0,           is_perfect: 1'b0},
      '{value: 32'd36,         typed: 1'b0, divisor_sum: '0,           is_perfect: 1'b0},
      '{value: 32'd997,        typed: 1'b1, divisor_sum: 35'd1,        is_perfect: 1'b0},
      '{value: 32'd65521,      typed: 1'b1, divisor_sum: 35'd1,        is_perfect: 1'b0},
      '{value: 32'd65536,      typed: 1'b0, divisor_sum: '0,           is_perfect: 1'b0},
      '{value: 32'd4095,       typed: 1'b0, divisor_sum: '0,           is_perfect: 1'b0},
      '{value: 32'd4097,       typed: 1'b0, divisor_sum: '0,           is_perfect: 1'b0},
      '{value: 32'd255,        typed: 1'b0, divisor_sum: '0,           is_perfect: 1'b0},
      '{value: 32'hFFFF_FFFF,  typed: 1'b0, divisor_sum: '0,           is_perfect: 1'b0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_value(row.value, row.typed, row.divisor_sum, row.is_perfect, 1'b1);
    end

    // Let the directed part drain so that the hold-off meets an idle block.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sum_q.size() != 0) @(posedge clk);

    // Random part opens with the long receiver hold-off while values keep coming.
    hold_go = 1'b1;
    for (int unsigned r = 0; r < N_RANDOM; r++) begin
      send_value(pick_value(r), 1'b0, '0, 1'b0, !(r >= 40 && r < 70));
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (sum_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d values (%0d directed incl. 0, 1, all-ones and five perfect numbers).",
             n_accepted, $size(dir_rows));
    $display("Checked %0d results, %0d flagged perfect, %0d mismatches.",
             n_checked, n_perfect_seen, n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: fails the run if it has not finished in time; all-ones is by far the slowest value.
  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
design/pds_pkg.sv
design/pds_if.sv
design/proper_divisor_sum_perfect_test.sv
test/tb_top.sv
